FILE: rtl/matrix_inverse_4x4_assert.svh
// ----------------------------------------------------------------------------
// matrix_inverse_4x4 assertion macros
// Concurrent check macros for the 4x4 inverter; they expand to nothing
// when the design is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_4X4_ASSERT_SVH
`define MATRIX_INVERSE_4X4_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent true at a clock edge implies consequent at the same edge
`define MI4_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mi4 implication check failed");

// condition must never hold at a clock edge
`define MI4_ASSERT_NEVER(lbl, ck, rst_n, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(cond)) \
		else $error("mi4 forbidden condition seen");

`else

`define MI4_ASSERT_IMPL(lbl, ck, rst_n, ante, cons)
`define MI4_ASSERT_NEVER(lbl, ck, rst_n, cond)

`endif

`endif

FILE: rtl/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared types and constants of the 4x4 matrix inverter.
// ----------------------------------------------------------------------------
package mi4_pkg;

	localparam int ELEM_W  = 16;
	localparam int IDX_W   = 4;
	localparam int N_ELEM  = 16;
	localparam int MINOR_W = 2 * ELEM_W + 1;
	localparam int COF_W   = 3 * ELEM_W + 1;
	localparam int PROD_W  = COF_W + ELEM_W;
	localparam int DET_W   = 4 * ELEM_W + 2;
	localparam int CNT_W   = $clog2(ELEM_W + 1);

	localparam logic [IDX_W-1:0] LAST_IDX = 4'hF;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t [N_ELEM-1:0] matrix_t;

	typedef struct packed {
		elem_t element_value;
		logic  last_element;
	} in_beat_t;

	typedef struct packed {
		elem_t              inverse_value;
		logic [IDX_W-1:0]   element_index;
		logic               singular;
		logic               saturated;
		logic               last_result;
	} out_beat_t;

	typedef struct packed {
		logic    valid;
		matrix_t matrix;
	} job_t;

	// n-th index of 0..3 with one index left out
	function automatic logic [1:0] skip_idx(logic [1:0] gap, logic [1:0] n);
		return (n < gap) ? n : n + 2'd1;
	endfunction

endpackage

FILE: rtl/mi4_front.sv
// ----------------------------------------------------------------------------
// mi4_front
// Loads elements into the matrix store and queues a snapshot of the whole
// matrix as a job when the last element arrives.
// ----------------------------------------------------------------------------
module mi4_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mi4_pkg::in_beat_t  din,
	output mi4_pkg::job_t      job,
	input  logic               job_pop
);

	logic [mi4_pkg::IDX_W-1:0] load_cnt_q;
	mi4_pkg::elem_t            st_q [mi4_pkg::N_ELEM];
	mi4_pkg::matrix_t          snap;
	mi4_pkg::matrix_t          jq_q [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                cnt_q;
	logic                      accept;
	logic                      job_push;

	assign full     = (cnt_q == 2'd2);
	assign accept   = push && !full;
	assign job_push = accept && din.last_element;

	// merge the incoming beat into the stored matrix
	always_comb begin
		for (int i = 0; i < mi4_pkg::N_ELEM; i++) begin
			if (load_cnt_q == mi4_pkg::IDX_W'(i)) begin
				snap[i] = din.element_value;
			end else begin
				snap[i] = st_q[i];
			end
		end
	end

	// write the element store
	always_ff @(posedge clk) begin
		if (accept) begin
			st_q[load_cnt_q] <= din.element_value;
		end
	end

	// advance the load position, restart after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (accept) begin
			if (din.last_element) begin
				load_cnt_q <= '0;
			end else begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
		end
	end

	// hold snapshots in the job queue
	always_ff @(posedge clk) begin
		if (job_push) begin
			jq_q[wr_ptr_q] <= snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (job_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (job_push && !job_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (job_pop && !job_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign job.valid  = (cnt_q != 2'd0);
	assign job.matrix = jq_q[rd_ptr_q];

endmodule

FILE: rtl/mi4_back.sv
// ----------------------------------------------------------------------------
// mi4_back
// Sequencer that forms the sixteen cofactors and the determinant with one
// shared multiplier, then divides each cofactor by the determinant with a
// restoring divider, one quotient bit a cycle, unless it is zero.
// ----------------------------------------------------------------------------
module mi4_back #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mi4_pkg::job_t      job,
	output logic               job_pop,
	output mi4_pkg::out_beat_t res,
	output logic               res_push,
	input  logic               res_full
);

	localparam int W     = mi4_pkg::ELEM_W;
	localparam int MW    = mi4_pkg::MINOR_W;
	localparam int CW    = mi4_pkg::COF_W;
	localparam int PW    = mi4_pkg::PROD_W;
	localparam int DW    = mi4_pkg::DET_W;
	localparam int NUM_W = CW + 2 * FRACTION_BITS;
	localparam int DSH_W = DW + W;
	localparam int RW    = (NUM_W > DSH_W) ? NUM_W : DSH_W;

	localparam logic [W:0] LIM_POS = {2'b00, {(W - 1){1'b1}}};
	localparam logic [W:0] LIM_NEG = {2'b01, {(W - 1){1'b0}}};

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_P1   = 12'b0000_0000_0010,
		ST_P2   = 12'b0000_0000_0100,
		ST_MN   = 12'b0000_0000_1000,
		ST_ML   = 12'b0000_0001_0000,
		ST_AC   = 12'b0000_0010_0000,
		ST_DM   = 12'b0000_0100_0000,
		ST_DA   = 12'b0000_1000_0000,
		ST_RD   = 12'b0001_0000_0000,
		ST_LD   = 12'b0010_0000_0000,
		ST_DV   = 12'b0100_0000_0000,
		ST_PUT  = 12'b1000_0000_0000
	} state_t;

	state_t                    state_q;
	logic [mi4_pkg::IDX_W-1:0] k_q;
	logic [1:0]                j_q;
	logic [mi4_pkg::CNT_W-1:0] cnt_q;
	mi4_pkg::matrix_t          m_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [MW-1:0]      minor_q;
	logic signed [CW-1:0]      acc_q;
	logic signed [CW-1:0]      cof_q;
	logic signed [DW-1:0]      det_q;
	logic signed [CW-1:0]      cof_mem [mi4_pkg::N_ELEM];
	logic signed [CW-1:0]      rd_q;
	logic                      neg_q;
	logic [RW-1:0]             rem_q;
	logic [RW-1:0]             dsh_q;
	logic [W:0]                quo_q;

	logic [1:0]           orow, ocol;
	logic [1:0]           r0, r1, r2, c0, c1, c2, cx, cy, cj;
	logic signed [CW-1:0] mul_a;
	logic signed [W-1:0]  mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [CW-1:0] acc_nx;
	logic signed [CW-1:0] cof_fin;
	logic [CW-1:0]        cof_mag;
	logic [DW-1:0]        det_mag;
	logic                 det_zero;
	logic                 div_ge;
	logic [W:0]           lim;
	logic                 sat;
	logic [W:0]           mag;
	logic                 ac_done;

	function automatic mi4_pkg::elem_t pick(mi4_pkg::matrix_t m, logic [1:0] r,
		logic [1:0] c);
		return $signed(m[{c, r}]);
	endfunction

	// minor rows and columns for the current cofactor
	assign orow = k_q[1:0];
	assign ocol = k_q[3:2];
	assign r0   = mi4_pkg::skip_idx(ocol, 2'd0);
	assign r1   = mi4_pkg::skip_idx(ocol, 2'd1);
	assign r2   = mi4_pkg::skip_idx(ocol, 2'd2);
	assign c0   = mi4_pkg::skip_idx(orow, 2'd0);
	assign c1   = mi4_pkg::skip_idx(orow, 2'd1);
	assign c2   = mi4_pkg::skip_idx(orow, 2'd2);
	assign cx   = (j_q == 2'd0) ? c1 : c0;
	assign cy   = (j_q == 2'd2) ? c1 : c2;
	assign cj   = (j_q == 2'd0) ? c0 : ((j_q == 2'd1) ? c1 : c2);

	// select the operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_P1: begin
				mul_a = CW'(pick(m_q, r1, cx));
				mul_b = pick(m_q, r2, cy);
			end
			ST_P2: begin
				mul_a = CW'(pick(m_q, r1, cy));
				mul_b = pick(m_q, r2, cx);
			end
			ST_ML: begin
				mul_a = CW'(minor_q);
				mul_b = pick(m_q, r0, cj);
			end
			ST_DM: begin
				mul_a = cof_q;
				mul_b = pick(m_q, ocol, 2'd0);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// accumulate the three minor terms with alternating sign
	always_comb begin
		case (j_q)
			2'd0:    acc_nx = CW'(prod_q);
			2'd1:    acc_nx = acc_q - CW'(prod_q);
			default: acc_nx = acc_q + CW'(prod_q);
		endcase
	end

	assign cof_fin  = (orow[0] ^ ocol[0]) ? -acc_nx : acc_nx;
	assign ac_done  = (j_q == 2'd2);
	assign det_zero = (det_q == '0);
	assign cof_mag  = rd_q[CW-1] ? CW'(-rd_q) : rd_q;
	assign det_mag  = det_q[DW-1] ? DW'(-det_q) : det_q;
	assign div_ge   = (rem_q >= dsh_q);

	// clip the quotient and apply the sign
	assign lim = neg_q ? LIM_NEG : LIM_POS;
	assign sat = !det_zero && (quo_q > lim);
	assign mag = sat ? lim : quo_q;

	always_comb begin
		res.element_index = k_q;
		res.singular      = det_zero;
		res.saturated     = sat;
		res.last_result   = (k_q == mi4_pkg::LAST_IDX);
		if (det_zero) begin
			res.inverse_value = '0;
		end else if (neg_q) begin
			res.inverse_value = W'(-mag);
		end else begin
			res.inverse_value = W'(mag);
		end
	end

	assign job_pop  = (state_q == ST_IDLE) && job.valid;
	assign res_push = (state_q == ST_PUT) && !res_full;

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= 2'd0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job.valid) begin
						k_q     <= '0;
						j_q     <= 2'd0;
						state_q <= ST_P1;
					end
				end
				ST_P1: state_q <= ST_P2;
				ST_P2: state_q <= ST_MN;
				ST_MN: state_q <= ST_ML;
				ST_ML: state_q <= ST_AC;
				ST_AC: begin
					if (!ac_done) begin
						j_q     <= j_q + 2'd1;
						state_q <= ST_P1;
					end else if (orow == 2'd0) begin
						state_q <= ST_DM;
					end else if (k_q == mi4_pkg::LAST_IDX) begin
						k_q     <= '0;
						state_q <= ST_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						j_q     <= 2'd0;
						state_q <= ST_P1;
					end
				end
				ST_DM: state_q <= ST_DA;
				ST_DA: begin
					k_q     <= k_q + 1'b1;
					j_q     <= 2'd0;
					state_q <= ST_P1;
				end
				ST_RD: state_q <= ST_LD;
				ST_LD: begin
					cnt_q   <= '0;
					state_q <= det_zero ? ST_PUT : ST_DV;
				end
				ST_DV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == mi4_pkg::CNT_W'(W)) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (!res_full) begin
						if (k_q == mi4_pkg::LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cofactor memory, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_AC && ac_done) begin
			cof_mem[k_q] <= cof_fin;
		end
		rd_q <= cof_mem[k_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				m_q   <= job.matrix;
				det_q <= '0;
			end
			ST_P1: prod_q <= mul_p;
			ST_P2: begin
				minor_q <= MW'(prod_q);
				prod_q  <= mul_p;
			end
			ST_MN: minor_q <= minor_q - MW'(prod_q);
			ST_ML: prod_q <= mul_p;
			ST_AC: begin
				acc_q <= acc_nx;
				cof_q <= cof_fin;
			end
			ST_DM: prod_q <= mul_p;
			ST_DA: det_q <= det_q + DW'(prod_q);
			ST_LD: begin
				neg_q <= rd_q[CW-1] ^ det_q[DW-1];
				rem_q <= RW'(cof_mag) << (2 * FRACTION_BITS);
				dsh_q <= RW'(det_mag) << W;
				quo_q <= '0;
			end
			ST_DV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[W-1:0], div_ge};
				dsh_q <= dsh_q >> 1;
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

endmodule

FILE: rtl/mi4_outq.sv
// ----------------------------------------------------------------------------
// mi4_outq
// Two-entry result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
module mi4_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	output logic               wr_full,
	input  mi4_pkg::out_beat_t wr_data,
	output logic               empty,
	input  logic               pop,
	output mi4_pkg::out_beat_t dout
);

	mi4_pkg::out_beat_t buf_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               do_rd;

	assign wr_full = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_rd   = pop && !empty;
	assign dout    = buf_q[rd_ptr_q];

	// hold written beats
	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/matrix_inverse_4x4.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 matrix inverse by cofactors and adjugate, signed fixed point.
// ----------------------------------------------------------------------------
// Input channel (push/full): one matrix element per beat, column-major,
// signed with FRACTION_BITS fraction bits; last_element marks the final
// beat and starts the inversion with the store as it stands.
// Result channel (empty/pop): sixteen beats per matrix in position order,
// each with its index, singular and saturated flags; last_result on index 15.
// Loading takes one beat a cycle while full is low. A finished matrix is
// queued (two deep), so the next matrix loads while the previous one is
// worked on. Inversion runs on the single shared multiplier and the
// one-bit-a-cycle divider: the sixteen cofactors and the determinant are
// formed first, then each cofactor is divided by the determinant; the
// divisions are skipped when the matrix is singular. The first result
// follows once all cofactors and the determinant are done.
// Reset empties both queues and restarts loading at position 0; the element
// store is not cleared. When the receiver stalls, results wait in a two-entry
// queue, then the sequencer holds, then full rises once the job queue fills.
// ----------------------------------------------------------------------------
`include "matrix_inverse_4x4_assert.svh"

module matrix_inverse_4x4 #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mi4_pkg::in_beat_t  din,
	output logic               empty,
	input  logic               pop,
	output mi4_pkg::out_beat_t dout
);

	mi4_pkg::job_t      job;
	logic               job_pop;
	mi4_pkg::out_beat_t res;
	logic               res_push;
	logic               res_full;

	// load and queue matrices
	mi4_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.din     (din),
		.job     (job),
		.job_pop (job_pop)
	);

	// cofactors, determinant and division
	mi4_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.job_pop  (job_pop),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full)
	);

	// result queue
	mi4_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_full (res_full),
		.wr_data (res),
		.empty   (empty),
		.pop     (pop),
		.dout    (dout)
	);

	`MI4_ASSERT_NEVER(a_no_push_full, clk, arst_n, res_push && res_full)
	`MI4_ASSERT_IMPL(a_job_pop_valid, clk, arst_n, job_pop, job.valid)
	`MI4_ASSERT_IMPL(a_last_at_end, clk, arst_n, !empty, dout.last_result == (dout.element_index == mi4_pkg::LAST_IDX))
	`MI4_ASSERT_IMPL(a_singular_zero, clk, arst_n, !empty && dout.singular, dout.inverse_value == '0 && !dout.saturated)

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of matrix_inverse_4x4
// Loads 4x4 Q8.8 matrices beat by beat and checks every inverse beat against
// an exact cofactor/adjugate predictor. It covers directed corner matrices and
// random matrices under three idling patterns of sender and receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC       = 8;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYC  = 50;

	typedef logic signed [127:0] wide_t;
	typedef enum int {MAT_SMALL, MAT_FULL, MAT_SINGULAR, MAT_EARLY, MAT_OVERLONG} mat_kind_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	mi4_pkg::in_beat_t  din;
	logic               empty;
	logic               pop;
	mi4_pkg::out_beat_t dout;

	// predictor state
	mi4_pkg::elem_t     store [mi4_pkg::N_ELEM];
	int                 load_pos;
	mi4_pkg::out_beat_t inverse_q [$];

	int send_idle;
	int recv_idle;
	int errors;
	int idle_cnt;

	matrix_inverse_4x4 #(.FRACTION_BITS(FRAC)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.din    (din),
		.empty  (empty),
		.pop    (pop),
		.dout   (dout)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// element at row, column of the stored matrix, sign extended
	function automatic wide_t elem_at(int row, int col);
		wide_t v;
		v = store[col * 4 + row];
		return v;
	endfunction

	function automatic wide_t cofactor_of(int k);
		int    orow, ocol, n;
		int    r [3];
		int    c [3];
		wide_t m0, m1, m2, acc;
		orow = k % 4;
		ocol = k / 4;
		n = 0;
		for (int i = 0; i < 4; i++) if (i != ocol) begin r[n] = i; n++; end
		n = 0;
		for (int i = 0; i < 4; i++) if (i != orow) begin c[n] = i; n++; end
		m0 = elem_at(r[1], c[1]) * elem_at(r[2], c[2]) - elem_at(r[1], c[2]) * elem_at(r[2], c[1]);
		m1 = elem_at(r[1], c[0]) * elem_at(r[2], c[2]) - elem_at(r[1], c[2]) * elem_at(r[2], c[0]);
		m2 = elem_at(r[1], c[0]) * elem_at(r[2], c[1]) - elem_at(r[1], c[1]) * elem_at(r[2], c[0]);
		acc = m0 * elem_at(r[0], c[0]) - m1 * elem_at(r[0], c[1]) + m2 * elem_at(r[0], c[2]);
		return ((orow + ocol) % 2 == 1) ? -acc : acc;
	endfunction

	// store the beat; on the final one queue the sixteen inverse beats
	task automatic predict_inverse(mi4_pkg::in_beat_t b);
		wide_t              cof [mi4_pkg::N_ELEM];
		wide_t              det, q, lim, num;
		logic               neg;
		mi4_pkg::out_beat_t o;
		store[load_pos] = b.element_value;
		load_pos = (load_pos + 1) % mi4_pkg::N_ELEM;
		if (!b.last_element) return;
		load_pos = 0;
		for (int k = 0; k < mi4_pkg::N_ELEM; k++) cof[k] = cofactor_of(k);
		det = 0;
		for (int k = 0; k < 4; k++) det += cof[k * 4] * elem_at(k, 0);
		for (int k = 0; k < mi4_pkg::N_ELEM; k++) begin
			o = '0;
			o.element_index = mi4_pkg::IDX_W'(k);
			o.last_result = (k == mi4_pkg::N_ELEM - 1);
			if (det == 0) begin
				o.singular = 1'b1;
			end else begin
				neg = (cof[k] < 0) != (det < 0);
				num = ((cof[k] < 0) ? -cof[k] : cof[k]) <<< (2 * FRAC);
				q = num / ((det < 0) ? -det : det);
				lim = neg ? 32768 : 32767;
				if (q > lim) begin
					o.saturated = 1'b1;
					q = lim;
				end
				o.inverse_value = neg ? mi4_pkg::elem_t'(-q) : mi4_pkg::elem_t'(q);
			end
			inverse_q.push_back(o);
		end
	endtask

	// offer one beat until it is taken
	task automatic send_beat(logic signed [mi4_pkg::ELEM_W-1:0] v, logic last);
		mi4_pkg::in_beat_t b;
		b.element_value = v;
		b.last_element = last;
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				din <= b;
				@(posedge clk);
				if (!full) begin
					predict_inverse(b);
					break;
				end
			end
		end
	endtask

	task automatic send_matrix(mat_kind_t kind);
		mi4_pkg::elem_t m [mi4_pkg::N_ELEM];
		int             len;
		len = mi4_pkg::N_ELEM;
		for (int i = 0; i < mi4_pkg::N_ELEM; i++) begin
			if (kind == MAT_SMALL) begin
				if (i % 5 == 0)
					m[i] = mi4_pkg::elem_t'(($urandom_range(1) ? 1 : -1) *
						int'($urandom_range(256, 2048)));
				else
					m[i] = mi4_pkg::elem_t'(int'($urandom_range(512)) - 256);
			end else begin
				m[i] = mi4_pkg::elem_t'($urandom);
			end
		end
		// duplicate the first column into the last one
		if (kind == MAT_SINGULAR)
			for (int i = 0; i < 4; i++) m[12 + i] = m[i];
		if (kind == MAT_EARLY) len = $urandom_range(1, mi4_pkg::N_ELEM - 1);
		if (kind == MAT_OVERLONG) len = $urandom_range(mi4_pkg::N_ELEM + 1, mi4_pkg::N_ELEM + 4);
		for (int i = 0; i < len; i++)
			send_beat((i < mi4_pkg::N_ELEM) ? m[i] : mi4_pkg::elem_t'($urandom), i == len - 1);
	endtask

	task automatic test_identity();
		for (int i = 0; i < mi4_pkg::N_ELEM; i++)
			send_beat((i % 5 == 0) ? 16'sh0100 : 16'sh0000, i == mi4_pkg::N_ELEM - 1);
	endtask

	task automatic test_singular_early();
		// zero the first column with an early last mark
		for (int i = 0; i < 4; i++) send_beat(16'sh0000, i == 3);
	endtask

	task automatic test_saturation();
		// restore the diagonal, then a tiny corner element blows up its inverse
		for (int i = 0; i < mi4_pkg::N_ELEM; i++)
			send_beat((i % 5 == 0) ? 16'sh0100 : 16'sh0000, i == mi4_pkg::N_ELEM - 1);
		send_beat(16'sh0001, 1'b1);
	endtask

	task automatic test_extremes_overlong();
		mi4_pkg::elem_t ext [4];
		ext = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001};
		for (int i = 0; i < mi4_pkg::N_ELEM + 1; i++)
			send_beat(ext[$urandom_range(3)], i == mi4_pkg::N_ELEM);
	endtask

	task automatic test_random(int s_idle, int r_idle, int n_mat);
		int sel;
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int n = 0; n < n_mat; n++) begin
			sel = $urandom_range(9);
			case (sel)
				0, 1, 2, 3: send_matrix(MAT_SMALL);
				4, 5, 9:    send_matrix(MAT_FULL);
				6:          send_matrix(MAT_SINGULAR);
				7:          send_matrix(MAT_EARLY);
				default:    send_matrix(MAT_OVERLONG);
			endcase
		end
		@(negedge clk);
		push <= 1'b0;
		wait (inverse_q.size() == 0);
	endtask

	// drive pop on the falling edge
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
	end

	// check each accepted result beat
	always @(posedge clk) begin
		mi4_pkg::out_beat_t e;
		if (arst_n && pop && !empty) begin
			if (inverse_q.size() == 0) begin
				$error("result beat with nothing expected: %p", dout);
				errors++;
			end else begin
				e = inverse_q.pop_front();
				if (dout.inverse_value !== e.inverse_value) begin
					$error("inverse_value exp %0d got %0d", e.inverse_value, dout.inverse_value);
					errors++;
				end
				if (dout.element_index !== e.element_index) begin
					$error("element_index exp %0d got %0d", e.element_index, dout.element_index);
					errors++;
				end
				if (dout.singular !== e.singular) begin
					$error("singular exp %0b got %0b", e.singular, dout.singular);
					errors++;
				end
				if (dout.saturated !== e.saturated) begin
					$error("saturated exp %0b got %0b", e.saturated, dout.saturated);
					errors++;
				end
				if (dout.last_result !== e.last_result) begin
					$error("last_result exp %0b got %0b", e.last_result, dout.last_result);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int drain;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		din = '0;
		errors = 0;
		idle_cnt = 0;
		load_pos = 0;
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < mi4_pkg::N_ELEM; i++) store[i] = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_identity();
		test_singular_early();
		test_saturation();
		test_extremes_overlong();
		test_random(9, 82, 2);
		test_random(82, 9, 1);
		test_random(0, 0, 1);

		drain = 0;
		while (drain < DRAIN_CYC) begin
			@(posedge clk);
			drain++;
		end
		if (errors == 0 && inverse_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: matrix_inverse_4x4.f
+incdir+rtl
rtl/mi4_pkg.sv
rtl/mi4_front.sv
rtl/mi4_back.sv
rtl/mi4_outq.sv
rtl/matrix_inverse_4x4.sv
bench/tb_top.sv
